[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the port checker b2da_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion, also checked during reset.
`define ASSERT_CLK_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("assertion failed");

`endif

[hw/rtl/b2da_pkg.sv]
// ----------------------------------------------------------------------------
// b2da_pkg
// Types, constants and the double dabble step for the decimal converter.
// ----------------------------------------------------------------------------
`default_nettype none

package b2da_pkg;

    localparam int VALUE_W    = 64;
    localparam int CHAR_W     = 6;
    localparam int VALUE_BITS = 64;
    localparam int NUM_STAGES = 8;
    localparam int STAGE_BITS = (VALUE_BITS + NUM_STAGES - 1) / NUM_STAGES;
    localparam int PAD_BITS   = NUM_STAGES * STAGE_BITS;
    localparam int DIGITS     = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_W      = DIGITS * 4;
    localparam int IDX_W      = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef logic [BCD_W-1:0]    t_bcd;
    typedef logic [PAD_BITS-1:0] t_bin;
    typedef logic [IDX_W-1:0]    t_idx;

    typedef struct packed {
        t_bcd bcd;
        t_bin bin;
    } t_stage_data;

    // One double dabble iteration: adjust digits, shift next bit in.
    function automatic t_stage_data dabble_step(t_stage_data d);
        t_stage_data r;
        logic [BCD_W+PAD_BITS-1:0] w;
        r = d;
        for (int k = 0; k < DIGITS; k++) begin
            if (r.bcd[k*4 +: 4] >= 4'd5) begin
                r.bcd[k*4 +: 4] = r.bcd[k*4 +: 4] + 4'd3;
            end
        end
        w = {r.bcd, r.bin} << 1;
        r.bcd = w[BCD_W+PAD_BITS-1:PAD_BITS];
        r.bin = w[PAD_BITS-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/b2da_if.sv]
// ----------------------------------------------------------------------------
// b2da_if
// Request and response channels of the decimal converter.
// ----------------------------------------------------------------------------
`default_nettype none

interface b2da_in_if;
    import b2da_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface b2da_out_if;
    import b2da_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

`default_nettype wire

[hw/rtl/binary_to_decimal_ascii.sv]
// Throughput: one digit per cycle while the output is not stalled; a value of
// N digits (1 to 20) holds the serializer until its last digit is sent, and
// the 8-stage converter takes a request every cycle while it has room.
// Synchronous active-low reset empties all stages, the serializer and the
// output register.
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// 64-bit binary to decimal ASCII, MS digit first, no leading zeros.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii
    import b2da_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    b2da_in_if.sink    i_req,
    b2da_out_if.source o_rsp
);

    logic        s_valid [NUM_STAGES+1];
    logic        s_ready [NUM_STAGES+1];
    t_stage_data s_data  [NUM_STAGES+1];

    always_comb begin
        s_data[0]     = '0;
        s_data[0].bin[VALUE_BITS-1:0] = i_req.value[VALUE_BITS-1:0];
    end

    assign s_valid[0]  = i_req.valid;
    assign i_req.ready = s_ready[0];

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        b2da_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[g]),
            .o_ready (s_ready[g]),
            .i_data  (s_data[g]),
            .o_valid (s_valid[g+1]),
            .i_ready (s_ready[g+1]),
            .o_data  (s_data[g+1])
        );
    end

    // Serializer and output register
    logic              r_busy;
    t_bcd              r_bcd;
    t_idx              r_idx;
    logic              r_ov;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;

    t_idx              top_idx;
    logic              out_room;
    logic              ser_fire;
    logic              ser_end;
    logic [3:0]        cur_digit;

    always_comb begin
        top_idx = '0;
        for (int k = 0; k < DIGITS; k++) begin
            if (s_data[NUM_STAGES].bcd[k*4 +: 4] != 4'd0) begin
                top_idx = IDX_W'(k);
            end
        end
    end

    assign out_room  = !r_ov || o_rsp.ready;
    assign ser_fire  = r_busy && out_room;
    assign ser_end   = ser_fire && (r_idx == '0);
    assign cur_digit = r_bcd[r_idx*4 +: 4];

    assign s_ready[NUM_STAGES] = !r_busy || ser_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (s_valid[NUM_STAGES] && s_ready[NUM_STAGES]) begin
                r_busy <= 1'b1;
                r_bcd  <= s_data[NUM_STAGES].bcd;
                r_idx  <= top_idx;
            end else if (ser_end) begin
                r_busy <= 1'b0;
            end else if (ser_fire) begin
                r_idx <= r_idx - 1'b1;
            end

            if (ser_fire) begin
                r_ov   <= 1'b1;
                r_char <= ASCII_ZERO | {2'b00, cur_digit};
                r_last <= (r_idx == '0);
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_rsp.valid      = r_ov;
    assign o_rsp.digit_char = r_char;
    assign o_rsp.last_digit = r_last;

endmodule

`default_nettype wire

[hw/rtl/b2da_stage.sv]
// ----------------------------------------------------------------------------
// b2da_stage
// One pipeline stage: STAGE_BITS double dabble iterations, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_stage
    import b2da_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_stage_data i_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_stage_data      o_data
);

    logic        r_valid;
    t_stage_data r_data;
    t_stage_data n_data;

    always_comb begin
        n_data = i_data;
        for (int i = 0; i < STAGE_BITS; i++) begin
            n_data = dabble_step(n_data);
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

[hw/rtl/b2da_checker.sv]
// ----------------------------------------------------------------------------
// b2da_checker
// Port-level checks on the decimal converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module b2da_checker
    import b2da_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [CHAR_W-1:0] i_digit_char,
    input wire logic              i_last_digit
);

    // high when the next digit starts a new run
    logic r_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (i_out_valid && i_out_ready) begin
            r_first <= i_last_digit;
        end
    end

    `ASSERT_CLK_ALWAYS(a_rst_empty, !i_rst_n |=> !i_out_valid)
    `ASSERT_CLK(a_hold, i_out_valid && !i_out_ready |=> i_out_valid)
    `ASSERT_CLK(a_digit, i_out_valid |-> i_digit_char >= 6'd48 && i_digit_char <= 6'd57)
    `ASSERT_CLK(a_no_lead0, i_out_valid && r_first && i_digit_char == 6'd48 |-> i_last_digit)

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_digit_char (o_rsp.digit_char),
    .i_last_digit (o_rsp.last_digit)
);

`default_nettype wire

[tb/b2da_digit_checker.sv]
// ----------------------------------------------------------------------------
// b2da_digit_checker
// Watches the request and digit channels of the decimal converter, predicts
// the ASCII digit run of every accepted value and compares each digit field
// by field in arrival order.
// ----------------------------------------------------------------------------

module b2da_digit_checker
    import b2da_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    b2da_in_if   i_req,
    b2da_out_if  i_rsp,
    output int   o_fail_count,
    output int   o_digits_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIGITS = 20;
    localparam logic [VALUE_W-1:0] VALUE_MASK = {VALUE_W{1'b1}} >> (VALUE_W - VALUE_BITS);

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last_digit;
    } t_digit_char;

    t_digit_char digits_due[$];
    int          mismatches = 0;

    // Decimal digits of the request value, most significant first.
    function automatic void queue_decimal_digits(input logic [VALUE_W-1:0] raw);
        logic [VALUE_W-1:0] rest;
        logic [3:0]         rev [MAX_DIGITS];
        int                 n;
        t_digit_char        ch;
        rest = raw & VALUE_MASK;
        n = 0;
        do begin
            rev[n] = 4'(rest % 64'd10);
            rest = rest / 64'd10;
            n++;
        end while (rest != 0 && n < MAX_DIGITS);
        for (int k = n - 1; k >= 0; k--) begin
            ch.digit_char = ASCII_ZERO + CHAR_W'(rev[k]);
            ch.last_digit = (k == 0);
            digits_due.push_back(ch);
        end
    endfunction

    function automatic void note_mismatch(input string what, input t_digit_char want,
                                          input t_digit_char got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected char %0d last %0b, got char %0d last %0b",
                     $realtime, what, want.digit_char, want.last_digit,
                     got.digit_char, got.last_digit);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_digit_char got;
        t_digit_char want;
        if (i_rst_n) begin
            if (i_req.valid && i_req.ready) begin
                queue_decimal_digits(i_req.value);
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got.digit_char = i_rsp.digit_char;
                got.last_digit = i_rsp.last_digit;
                if (digits_due.size() == 0) begin
                    want = '0;
                    note_mismatch("digit with no request pending", want, got);
                end else begin
                    want = digits_due.pop_front();
                    if (got.digit_char !== want.digit_char
                        || got.last_digit !== want.last_digit) begin
                        note_mismatch("digit mismatch", want, got);
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_digits_due <= digits_due.size();
    end

endmodule

[tb/binary_to_decimal_ascii_tb.sv]
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_tb
// Drives corner and random 64-bit values into the decimal converter under
// changing sender and receiver idle rates plus one long output stall; the
// digit checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------

module binary_to_decimal_ascii_tb;
    import b2da_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 240;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [63:0] CORNER_VALUES [20] = '{
        64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd12345,
        64'd1000000007, 64'hFFFF_FFFF, 64'd1000000000000000000,
        64'd9999999999999999999, 64'd10000000000000000000,
        64'd12345678901234567890, 64'h8000_0000_0000_0000,
        64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
        64'hFFFF_FFFF_FFFF_FFF6, 64'hFFFF_FFFF_FFFF_FFFE,
        64'hFFFF_FFFF_FFFF_FFFF, 64'd7
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   phase = 0;
    int   hold_left = 0;
    bit   held_off = 1'b0;
    int   cycle_count = 0;
    int   fail_count;
    int   digits_due;

    b2da_in_if  req_bus();
    b2da_out_if rsp_bus();

    binary_to_decimal_ascii i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    b2da_digit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_bus),
        .i_rsp        (rsp_bus),
        .o_fail_count (fail_count),
        .o_digits_due (digits_due)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: idle rate per phase; one long hold-off when the last phase starts.
    always @(posedge i_clk) begin
        if (phase == 2 && !held_off) begin
            held_off <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= (phase == 0 ? 87 : phase == 1 ? 33 : 0));
        end
    end

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        logic [63:0] p;
        int          kind;
        int          nbits;
        v = {$urandom, $urandom};
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            nbits = $urandom_range(1, 64);
            if (nbits < 64) begin
                v = v & ((64'd1 << nbits) - 64'd1);
            end
        end else if (kind < 7) begin
            v = 64'($urandom_range(0, 999));
        end else if (kind == 7) begin
            p = 64'd1;
            repeat ($urandom_range(0, 19)) p = p * 64'd10;
            v = p + 64'($urandom_range(0, 2)) - 64'd1;
        end
        return v;
    endfunction

    task automatic offer_value(input logic [63:0] v);
        while ($urandom_range(0, 99) < (phase == 0 ? 33 : phase == 1 ? 87 : 0)) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.value <= v;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
    endtask

    initial begin
        req_bus.valid <= 1'b0;
        req_bus.value <= '0;
        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (CORNER_VALUES[n]) offer_value(CORNER_VALUES[n]);
        for (int ph = 0; ph < 3; ph++) begin
            phase <= ph;
            repeat (RANDOM_ITEMS / 3) offer_value(random_value());
        end
        req_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (digits_due != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && digits_due == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/b2da_pkg.sv
hw/rtl/b2da_if.sv
hw/rtl/b2da_stage.sv
hw/rtl/binary_to_decimal_ascii.sv
hw/rtl/b2da_checker.sv
tb/b2da_digit_checker.sv
tb/binary_to_decimal_ascii_tb.sv
